// ===== design/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Beat types and constants shared by the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CpWidth = 21;

	// U+FFFD, sent in place of bad input
	localparam logic [CpWidth-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

	// Input beat: one raw byte or an end-of-input mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_item_t;

	// Output beat: one decoded character or an end mark
	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic               substituted;
		logic               stream_ended;
	} out_item_t;

endpackage

// ===== design/utf8_byte_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder
// Decodes one UTF-8 byte per beat into 21-bit code points, with U+FFFD
// replacement for bad input and an optional 16-bit limit.
// ----------------------------------------------------------------------------
// A byte is held in the input register while it is decoded; its result beat
// (if any) is then written to the result register, which drives out_valid.
// Throughput: one byte per cycle; the decode state updates in a single pass.
// The input stalls only while a result is held by a stalled output.
// Reset (arst_n low) clears the decode state, the limit register and both
// valid flags.
module utf8_byte_stream_decoder
	import utf8d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic               limit_q;
	logic               valid_s1;
	in_item_t           item_s1;
	logic [1:0]         expected_q;
	logic [CpWidth-1:0] partial_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic               emit;
	out_item_t          result;
	logic [1:0]         expected_nxt;
	logic [CpWidth-1:0] partial_nxt;
	logic [CpWidth-1:0] merged;
	logic [7:0]         b;
	logic               out_free;
	logic               advance;
	logic               in_take;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 1'b0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Handshake: a byte moves on when its result (if any) has a slot
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// Merge continuation payload at the slot the remaining count selects
	assign b = item_s1.data_byte;
	always_comb begin
		unique case (expected_q)
			2'd3:    merged = partial_q | {3'b0, b[5:0], 12'b0};
			2'd2:    merged = partial_q | {9'b0, b[5:0], 6'b0};
			default: merged = partial_q | {15'b0, b[5:0]};
		endcase
	end

	// Decode one byte against the open sequence
	always_comb begin
		emit                = 1'b0;
		result.code_point   = '0;
		result.substituted  = 1'b0;
		result.stream_ended = 1'b0;
		expected_nxt        = expected_q;
		partial_nxt         = partial_q;
		if (item_s1.end_of_input) begin
			emit                = 1'b1;
			result.stream_ended = 1'b1;
			expected_nxt        = 2'd0;
			partial_nxt         = '0;
		end else if (expected_q == 2'd0) begin
			priority if (!b[7]) begin
				emit              = 1'b1;
				result.code_point = {13'b0, b};
			end else if (b[7:5] == 3'b110) begin
				partial_nxt  = {10'b0, b[4:0], 6'b0};
				expected_nxt = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				partial_nxt  = {5'b0, b[3:0], 12'b0};
				expected_nxt = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				partial_nxt  = {b[2:0], 18'b0};
				expected_nxt = 2'd3;
			end else begin
				emit               = 1'b1;
				result.code_point  = REPLACEMENT_CHAR;
				result.substituted = 1'b1;
			end
		end else if (b[7:6] != 2'b10) begin
			// drop the partial sequence, consume the byte
			emit               = 1'b1;
			result.code_point  = REPLACEMENT_CHAR;
			result.substituted = 1'b1;
			expected_nxt       = 2'd0;
			partial_nxt        = '0;
		end else if (expected_q == 2'd1) begin
			emit         = 1'b1;
			expected_nxt = 2'd0;
			partial_nxt  = '0;
			if (limit_q && (merged[20:16] != 5'd0)) begin
				result.code_point  = REPLACEMENT_CHAR;
				result.substituted = 1'b1;
			end else begin
				result.code_point = merged;
			end
		end else begin
			expected_nxt = expected_q - 2'd1;
			partial_nxt  = merged;
		end
	end

	// Decode state: advance only when the byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= 2'd0;
			partial_q  <= '0;
		end else if (advance) begin
			expected_q <= expected_nxt;
			partial_q  <= partial_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// End beats carry no character
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stream_ended |->
			out_item.code_point == '0 && !out_item.substituted)
		else $error("end beat carries a character");

	// Substitution always sends U+FFFD
	a_subst_fffd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.substituted |-> out_item.code_point == REPLACEMENT_CHAR)
		else $error("substituted beat is not U+FFFD");

	// End of input closes any open sequence
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_input |=> expected_q == 2'd0 && partial_q == '0)
		else $error("sequence still open after end of input");

	// Stall only with a held byte
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && emit && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder testbench
// Drives directed and random byte streams through the decoder, with sender
// bursts, receiver stalls and one long hold-off. A scoreboard predicts each
// result beat from the accepted bytes and checks the decoder output in order.
// ----------------------------------------------------------------------------
module testbench;
	import utf8d_pkg::*;

	// Predicts decoded characters and checks them against the output beats
	class decode_scoreboard;
		bit               limit_16;
		bit [1:0]         bytes_left;
		logic [CpWidth-1:0] partial;
		out_item_t        expected_chars[$];
		int               failures;

		function new();
			limit_16 = 1'b0;
			bytes_left = '0;
			partial = '0;
			failures = 0;
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		// Advance the decode state by one accepted byte; queue any result
		function void note_byte(in_item_t it);
			out_item_t          r;
			bit                 emit;
			logic [CpWidth-1:0] v;
			int                 shift;
			r = '0;
			emit = 1'b0;
			if (it.end_of_input) begin
				bytes_left = '0;
				partial = '0;
				r.stream_ended = 1'b1;
				emit = 1'b1;
			end else if (bytes_left == 0) begin
				casez (it.data_byte)
					8'b0???????: begin
						r.code_point = CpWidth'(it.data_byte);
						emit = 1'b1;
					end
					8'b110?????: begin
						partial = CpWidth'({it.data_byte[4:0], 6'b0});
						bytes_left = 2'd1;
					end
					8'b1110????: begin
						partial = CpWidth'({it.data_byte[3:0], 12'b0});
						bytes_left = 2'd2;
					end
					8'b11110???: begin
						partial = CpWidth'({it.data_byte[2:0], 18'b0});
						bytes_left = 2'd3;
					end
					default: begin
						r.code_point = REPLACEMENT_CHAR;
						r.substituted = 1'b1;
						emit = 1'b1;
					end
				endcase
			end else if (it.data_byte[7:6] != 2'b10) begin
				// drop the open sequence, the bad byte is consumed
				bytes_left = '0;
				partial = '0;
				r.code_point = REPLACEMENT_CHAR;
				r.substituted = 1'b1;
				emit = 1'b1;
			end else begin
				shift = 6 * (int'(bytes_left) - 1);
				partial = partial | (CpWidth'(it.data_byte[5:0]) << shift);
				bytes_left = bytes_left - 2'd1;
				if (bytes_left == 0) begin
					v = partial;
					partial = '0;
					if (limit_16 && v > 21'h00FFFF) begin
						r.code_point = REPLACEMENT_CHAR;
						r.substituted = 1'b1;
					end else begin
						r.code_point = v;
					end
					emit = 1'b1;
				end
			end
			if (emit) expected_chars.push_back(r);
		endfunction

		// Compare one output beat with the oldest prediction
		function void check_char(out_item_t got);
			out_item_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected result beat: code_point %0h", got.code_point);
				failures++;
				return;
			end
			want = expected_chars.pop_front();
			if (got.code_point !== want.code_point) begin
				$error("code_point: expected %0h, actual %0h", want.code_point, got.code_point);
				failures++;
			end
			if (got.substituted !== want.substituted) begin
				$error("substituted: expected %0b, actual %0b", want.substituted,
					got.substituted);
				failures++;
			end
			if (got.stream_ended !== want.stream_ended) begin
				$error("stream_ended: expected %0b, actual %0b", want.stream_ended,
					got.stream_ended);
				failures++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_wdata;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	decode_scoreboard sb = new();
	in_item_t         stim_q[$];
	bit               hold_request = 1'b0;

	// byte in bits 7:0, end-of-input mark in bit 8
	bit [8:0] directed_seq[$] = '{
		9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
		9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
		9'h080, 9'h0BF, 9'h0F8, 9'h0FF, 9'h0E2, 9'h041, 9'h0C3, 9'h1FF,
		9'h100, 9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF
	};

	utf8_byte_stream_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic in_item_t mk_beat(bit [7:0] b, bit eoi);
		in_item_t it;
		it.data_byte = b;
		it.end_of_input = eoi;
		return it;
	endfunction

	// Check output beats and stall on a changing pattern, with one long hold
	initial begin : receiver
		int hold_left;
		int phase_left;
		int stall_mode;
		int cyc;
		hold_left = 0;
		phase_left = 0;
		stall_mode = 0;
		cyc = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (arst_n && out_valid && !out_stall) sb.check_char(out_item);
			if (phase_left == 0) begin
				stall_mode = $urandom_range(3);
				phase_left = $urandom_range(20, 120);
			end
			phase_left--;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 300;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(99) < 25);
					2: out_stall <= ($urandom_range(99) < 75);
					default: out_stall <= (cyc % 3 == 0);
				endcase
			end
		end
	end

	// Hold one beat on the input until the decoder takes it
	task automatic send_beat(in_item_t it);
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.note_byte(it);
	endtask

	// Send the queued stimulus in bursts with random gaps
	task automatic drive_stim(int gap_max);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 40);
		while (stim_q.size() != 0) begin
			send_beat(stim_q.pop_front());
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(gap_max);
				if (gap != 0 && stim_q.size() != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	// Write the limit register once the decoder has drained
	task automatic write_limit(bit v);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.limit_16 = v;
	endtask

	// Build mostly well-formed sequences, with broken ones and noise mixed in
	task automatic build_random(int n);
		int       pick;
		int       len;
		int       conts;
		bit [7:0] b;
		while (stim_q.size() < n) begin
			pick = $urandom_range(99);
			len = $urandom_range(2, 4);
			case (len)
				2: b = 8'hC0 | 8'($urandom_range(31));
				3: b = 8'hE0 | 8'($urandom_range(15));
				default: b = 8'hF0 | 8'($urandom_range(7));
			endcase
			if (pick < 20) begin
				stim_q.push_back(mk_beat(8'($urandom_range(127)), 1'b0));
			end else if (pick < 70) begin
				stim_q.push_back(mk_beat(b, 1'b0));
				repeat (len - 1) stim_q.push_back(mk_beat(8'h80 | 8'($urandom_range(63)), 1'b0));
			end else if (pick < 80) begin
				// cut the sequence short with a byte that is not a continuation
				conts = $urandom_range(len - 2);
				stim_q.push_back(mk_beat(b, 1'b0));
				repeat (conts) stim_q.push_back(mk_beat(8'h80 | 8'($urandom_range(63)), 1'b0));
				b = 8'($urandom);
				if (b[7:6] == 2'b10) b[6] = 1'b1;
				stim_q.push_back(mk_beat(b, 1'b0));
			end else if (pick < 85) begin
				conts = $urandom_range(len - 2);
				stim_q.push_back(mk_beat(b, 1'b0));
				repeat (conts) stim_q.push_back(mk_beat(8'h80 | 8'($urandom_range(63)), 1'b0));
				stim_q.push_back(mk_beat(8'($urandom), 1'b1));
			end else if (pick < 90) begin
				stim_q.push_back(mk_beat(8'($urandom), 1'b1));
			end else begin
				stim_q.push_back(mk_beat(8'($urandom), 1'b0));
			end
		end
	endtask

	initial begin : main
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edge values and every special case, no limit
		write_limit(1'b0);
		foreach (directed_seq[i]) stim_q.push_back(mk_beat(directed_seq[i][7:0], directed_seq[i][8]));
		drive_stim(3);

		// directed: limit on, one value above 16 bits and one at the top of it
		write_limit(1'b1);
		stim_q.push_back(mk_beat(8'hF0, 1'b0));
		stim_q.push_back(mk_beat(8'h9F, 1'b0));
		stim_q.push_back(mk_beat(8'h98, 1'b0));
		stim_q.push_back(mk_beat(8'h80, 1'b0));
		stim_q.push_back(mk_beat(8'hEF, 1'b0));
		stim_q.push_back(mk_beat(8'hBF, 1'b0));
		stim_q.push_back(mk_beat(8'hBF, 1'b0));
		drive_stim(0);

		// random phases, alternating the limit; hold the receiver off in one
		for (int ph = 0; ph < 4; ph++) begin
			write_limit(ph[0]);
			build_random(475);
			if (ph == 2) hold_request = 1'b1;
			drive_stim((ph == 1) ? 0 : 6);
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
